@@ hw/rtl/unix_to_bcd_calendar_core_macros.svh @@
// assertion macros used by the calendar core top level
`ifndef UNIX_TO_BCD_CALENDAR_CORE_MACROS_SVH
`define UNIX_TO_BCD_CALENDAR_CORE_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define UBC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("calendar core assertion failed");

// next-cycle implication, disabled while reset is high
`define UBC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("calendar core assertion failed");

`endif

@@ hw/rtl/ubc_pkg.sv @@
// shared constants, types and helper functions for the calendar core
`default_nettype none

package ubc_pkg;

   // reciprocal multipliers: floor(x / d) == (x * RECIP) >> SHIFT over the used range
   localparam logic [25:0] RECIP_675  = 26'd50903317;  // shift 35, x below 2^25
   localparam logic [15:0] RECIP_3600 = 16'd37283;     // shift 27, x below 86400
   localparam logic [12:0] RECIP_60   = 13'd4370;      // shift 18, x below 3600
   localparam logic [16:0] RECIP_7    = 17'd74899;     // shift 19, x below 2^16
   localparam logic [15:0] RECIP_1460 = 16'd45965;     // applied to x >> 2, shift 24
   localparam logic [17:0] RECIP_365  = 18'd183861;    // shift 26, x below 146097
   localparam logic [12:0] RECIP_153  = 13'd6854;      // shift 20, x below 2048

   localparam logic [19:0] EPOCH_SHIFT  = 20'd719468;
   localparam logic [19:0] ERA4_START   = 20'd584388;
   localparam logic [19:0] ERA5_START   = 20'd730485;
   localparam logic [17:0] DAYS_4Y      = 18'd36524;
   localparam logic [17:0] DAYS_8Y      = 18'd73048;
   localparam logic [17:0] DAYS_12Y     = 18'd109572;
   localparam logic [17:0] DAYS_ERA_END = 18'd146096;
   localparam logic [11:0] YEAR_LOW     = 12'd2000;
   localparam logic [11:0] YEAR_HIGH    = 12'd2099;
   localparam logic [11:0] ERA4_YEAR    = 12'd1600;

   // civil date leaving the days-to-date pipeline
   typedef struct packed {
      logic       in_range;
      logic [6:0] year_ofs;  // year - 2000
      logic [3:0] month;
      logic [4:0] mday;
   } civil_type;

   // two-digit bcd of a value below 100
   function automatic logic [7:0] bcd2(input logic [6:0] v);
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [3:0]  ones;
      prod = 15'(v) * 15'd205;
      tens = prod[14:11];
      ones = 4'(v - 7'(tens) * 7'd10);
      return {tens, ones};
   endfunction

   // first day of year (march based) of each month index
   function automatic logic [8:0] month_base(input logic [3:0] mp);
      logic [8:0] base;
      case (mp)
         4'd0:    base = 9'd0;
         4'd1:    base = 9'd31;
         4'd2:    base = 9'd61;
         4'd3:    base = 9'd92;
         4'd4:    base = 9'd122;
         4'd5:    base = 9'd153;
         4'd6:    base = 9'd184;
         4'd7:    base = 9'd214;
         4'd8:    base = 9'd245;
         4'd9:    base = 9'd275;
         4'd10:   base = 9'd306;
         4'd11:   base = 9'd337;
         default: base = 9'd0;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

@@ hw/rtl/ubc_civil_date.sv @@
// eight-stage pipeline from day count to civil year offset, month and day
`default_nettype none

module ubc_civil_date (
   input  wire logic              clock,
   input  wire logic              enable,
   input  wire logic [15:0]       days,
   output ubc_pkg::civil_type     date
);
   import ubc_pkg::*;

   // stage 1: shift to march-based epoch and split off the era
   logic [19:0] z;
   logic        s1_era5_in, s1_era5_ff;
   logic [17:0] s1_doe_in, s1_doe_ff;

   // stage 2: century and quadrennial corrections
   logic [31:0] q1460_prod;
   logic [6:0]  s2_q1460_in, s2_q1460_ff;
   logic [2:0]  s2_q36524_in, s2_q36524_ff;
   logic        s2_qlast_in, s2_qlast_ff;
   logic        s2_era5_ff;
   logic [17:0] s2_doe_ff;

   // stage 3: corrected day of era
   logic [17:0] s3_t_in, s3_t_ff;
   logic        s3_era5_ff;
   logic [17:0] s3_doe_ff;

   // stage 4: year of era
   logic [35:0] yoe_prod;
   logic [8:0]  s4_yoe_in, s4_yoe_ff;
   logic        s4_era5_ff;
   logic [17:0] s4_doe_ff;

   // stage 5: day of year
   logic [1:0]  yoe_cent;
   logic [17:0] year_days;
   logic [8:0]  s5_doy_in, s5_doy_ff;
   logic [8:0]  s5_yoe_ff;
   logic        s5_era5_ff;

   // stage 6: month index
   logic [10:0] mp_arg;
   logic [23:0] mp_prod;
   logic [3:0]  s6_mp_in, s6_mp_ff;
   logic [8:0]  s6_doy_ff;
   logic [8:0]  s6_yoe_ff;
   logic        s6_era5_ff;

   // stage 7: month, day and full year
   logic [4:0]  s7_mday_in, s7_mday_ff;
   logic [3:0]  s7_month_in, s7_month_ff;
   logic [11:0] s7_year_in, s7_year_ff;

   // stage 8: range check
   civil_type   s8_date_in, s8_date_ff;

   always_comb begin
      z          = 20'(days) + EPOCH_SHIFT;
      s1_era5_in = (z >= ERA5_START);
      s1_doe_in  = 18'(z - (s1_era5_in ? ERA5_START : ERA4_START));
   end

   always_comb begin
      q1460_prod   = 32'(s1_doe_ff[17:2]) * 32'(RECIP_1460);
      s2_q1460_in  = q1460_prod[30:24];
      s2_q36524_in = 3'(s1_doe_ff >= DAYS_4Y) + 3'(s1_doe_ff >= DAYS_8Y)
                   + 3'(s1_doe_ff >= DAYS_12Y) + 3'(s1_doe_ff >= DAYS_ERA_END);
      s2_qlast_in  = (s1_doe_ff == DAYS_ERA_END);
   end

   assign s3_t_in = s2_doe_ff - 18'(s2_q1460_ff) + 18'(s2_q36524_ff) - 18'(s2_qlast_ff);

   always_comb begin
      yoe_prod  = 36'(s3_t_ff) * 36'(RECIP_365);
      s4_yoe_in = yoe_prod[34:26];
   end

   always_comb begin
      yoe_cent  = 2'(s4_yoe_ff >= 9'd100) + 2'(s4_yoe_ff >= 9'd200)
                + 2'(s4_yoe_ff >= 9'd300);
      year_days = 18'(s4_yoe_ff) * 18'd365 + 18'(s4_yoe_ff[8:2]) - 18'(yoe_cent);
      s5_doy_in = 9'(s4_doe_ff - year_days);
   end

   always_comb begin
      mp_arg   = 11'(s5_doy_ff) * 11'd5 + 11'd2;
      mp_prod  = 24'(mp_arg) * 24'(RECIP_153);
      s6_mp_in = mp_prod[23:20];
   end

   // march-based month back to january-based, january and february roll the year
   always_comb begin
      s7_mday_in  = 5'(s6_doy_ff - month_base(s6_mp_ff) + 9'd1);
      s7_month_in = (s6_mp_ff < 4'd10) ? (s6_mp_ff + 4'd3) : (s6_mp_ff - 4'd9);
      s7_year_in  = (s6_era5_ff ? YEAR_LOW : ERA4_YEAR) + 12'(s6_yoe_ff)
                  + 12'(s7_month_in <= 4'd2);
   end

   always_comb begin
      s8_date_in.in_range = (s7_year_ff >= YEAR_LOW) && (s7_year_ff <= YEAR_HIGH);
      s8_date_in.year_ofs = 7'(s7_year_ff - YEAR_LOW);
      s8_date_in.month    = s7_month_ff;
      s8_date_in.mday     = s7_mday_ff;
   end

   // stage registers, all held while the pipeline is stalled
   always_ff @(posedge clock) begin
      if (enable) begin
         s1_era5_ff   <= s1_era5_in;
         s1_doe_ff    <= s1_doe_in;
         s2_q1460_ff  <= s2_q1460_in;
         s2_q36524_ff <= s2_q36524_in;
         s2_qlast_ff  <= s2_qlast_in;
         s2_era5_ff   <= s1_era5_ff;
         s2_doe_ff    <= s1_doe_ff;
         s3_t_ff      <= s3_t_in;
         s3_era5_ff   <= s2_era5_ff;
         s3_doe_ff    <= s2_doe_ff;
         s4_yoe_ff    <= s4_yoe_in;
         s4_era5_ff   <= s3_era5_ff;
         s4_doe_ff    <= s3_doe_ff;
         s5_doy_ff    <= s5_doy_in;
         s5_yoe_ff    <= s4_yoe_ff;
         s5_era5_ff   <= s4_era5_ff;
         s6_mp_ff     <= s6_mp_in;
         s6_doy_ff    <= s5_doy_ff;
         s6_yoe_ff    <= s5_yoe_ff;
         s6_era5_ff   <= s5_era5_ff;
         s7_mday_ff   <= s7_mday_in;
         s7_month_ff  <= s7_month_in;
         s7_year_ff   <= s7_year_in;
         s8_date_ff   <= s8_date_in;
      end
   end

   assign date = s8_date_ff;

endmodule

`default_nettype wire

@@ hw/rtl/unix_to_bcd_calendar_core.sv @@
// top level: unix seconds to bcd real-time-clock time and date words
//
// req channel carries one 32-bit unix seconds count per transaction.
// rsp channel returns one transaction per request, in order: the bcd time
// word and date word in tdata, and an out-of-range flag in tuser when the
// civil year lies outside 2000..2099 (both words are then zero).
// the block is an 11-stage pipeline: one request is taken every cycle when
// the receiver does not stall. the stage count is set by the chain of
// reciprocal multipliers (days split, year of era, month index) each followed
// by its own register. all stages advance together; when rsp_tready is low
// with a result waiting, the whole pipeline holds and req_tready drops, so
// nothing is lost or repeated. reset clears the stage valid bits only; no
// result is pending after reset and the first request may arrive in the
// next cycle.
`default_nettype none
`include "unix_to_bcd_calendar_core_macros.svh"

module unix_to_bcd_calendar_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] unix_seconds
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // [21:0] time_word, [45:22] date_word, [47:46] zero
   output logic             rsp_tuser    // [0] out_of_range
);
   import ubc_pkg::*;

   localparam int NUM_STAGES = 11;
   localparam int TIME_DELAY = 4;

   typedef struct packed {
      logic [4:0] hh;
      logic [5:0] mi;
      logic [5:0] ss;
      logic [2:0] wday;
   } clock_type;

   logic                  advance;
   logic [NUM_STAGES-1:0] valid_in, valid_ff;

   // stage 1: days = seconds / 86400 as (seconds >> 7) / 675
   logic [50:0] day_prod;
   logic [24:0] s1_x_ff;
   logic [6:0]  s1_lo_ff;
   logic [15:0] s1_days_in, s1_days_ff;

   // stage 2: day count and seconds of the day
   logic [24:0] day_secs;
   logic [16:0] s2_rem_in, s2_rem_ff;
   logic [15:0] s2_days_ff;

   // stage 3: hour and weekday products
   logic [32:0] hh_prod;
   logic [32:0] wd_prod;
   logic [15:0] wd_x;
   logic [4:0]  s3_hh_in, s3_hh_ff;
   logic [12:0] s3_wq_in, s3_wq_ff;
   logic [15:0] s3_wx_ff;
   logic [16:0] s3_rem_ff;

   // stage 4: hour, seconds of hour, weekday
   logic [11:0] s4_r2_in, s4_r2_ff;
   logic [2:0]  s4_wday_in, s4_wday_ff;
   logic [4:0]  s4_hh_ff;

   // stage 5: minute product
   logic [24:0] mi_prod;
   logic [5:0]  s5_mi_in, s5_mi_ff;
   logic [11:0] s5_r2_ff;
   logic [4:0]  s5_hh_ff;
   logic [2:0]  s5_wday_ff;

   // stage 6: time of day complete, then delayed to meet the date
   clock_type   s6_clk_in, s6_clk_ff;
   clock_type   clk_dly_ff [TIME_DELAY];

   civil_type   date;

   // output stage
   logic [47:0] rsp_data_in, rsp_data_ff;
   logic        rsp_oor_in, rsp_oor_ff;
   logic [7:0]  hh_bcd, mi_bcd, ss_bcd, yy_bcd, mo_bcd, md_bcd;
   logic [21:0] time_word;
   logic [23:0] date_word;

   // the pipeline moves as one whenever the output slot is free or being taken
   assign advance    = !valid_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = advance;
   assign valid_in   = {valid_ff[NUM_STAGES-2:0], req_tvalid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   // day split
   always_comb begin
      day_prod   = 51'(req_tdata[31:7]) * 51'(RECIP_675);
      s1_days_in = day_prod[50:35];
   end

   always_comb begin
      day_secs  = 25'(s1_days_ff) * 25'd675;
      s2_rem_in = {10'(s1_x_ff - day_secs), s1_lo_ff};
   end

   // hours and weekday quotient
   always_comb begin
      hh_prod  = 33'(s2_rem_ff) * 33'(RECIP_3600);
      s3_hh_in = hh_prod[31:27];
      wd_x     = s2_days_ff + 16'd3;
      wd_prod  = 33'(wd_x) * 33'(RECIP_7);
      s3_wq_in = wd_prod[31:19];
   end

   // 1970-01-01 was a thursday, so (days + 3) mod 7 counts from monday
   always_comb begin
      s4_r2_in   = 12'(s3_rem_ff - 17'(s3_hh_ff) * 17'd3600);
      s4_wday_in = 3'(s3_wx_ff - 16'(s3_wq_ff) * 16'd7) + 3'd1;
   end

   always_comb begin
      mi_prod  = 25'(s4_r2_ff) * 25'(RECIP_60);
      s5_mi_in = mi_prod[23:18];
   end

   always_comb begin
      s6_clk_in.hh   = s5_hh_ff;
      s6_clk_in.mi   = s5_mi_ff;
      s6_clk_in.ss   = 6'(s5_r2_ff - 12'(s5_mi_ff) * 12'd60);
      s6_clk_in.wday = s5_wday_ff;
   end

   // time path registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_x_ff    <= req_tdata[31:7];
         s1_lo_ff   <= req_tdata[6:0];
         s1_days_ff <= s1_days_in;
         s2_rem_ff  <= s2_rem_in;
         s2_days_ff <= s1_days_ff;
         s3_hh_ff   <= s3_hh_in;
         s3_wq_ff   <= s3_wq_in;
         s3_wx_ff   <= wd_x;
         s3_rem_ff  <= s2_rem_ff;
         s4_r2_ff   <= s4_r2_in;
         s4_wday_ff <= s4_wday_in;
         s4_hh_ff   <= s3_hh_ff;
         s5_mi_ff   <= s5_mi_in;
         s5_r2_ff   <= s4_r2_ff;
         s5_hh_ff   <= s4_hh_ff;
         s5_wday_ff <= s4_wday_ff;
         s6_clk_ff  <= s6_clk_in;
         clk_dly_ff[0] <= s6_clk_ff;
         for (int i = 1; i < TIME_DELAY; i++) begin
            clk_dly_ff[i] <= clk_dly_ff[i-1];
         end
      end
   end

   // days to civil date, stages 3 to 10
   ubc_civil_date u_civil_date (
      .clock  (clock),
      .enable (advance),
      .days   (s2_days_ff),
      .date   (date)
   );

   // bcd packing, words forced to zero outside the supported years
   always_comb begin
      hh_bcd    = bcd2(7'(clk_dly_ff[TIME_DELAY-1].hh));
      mi_bcd    = bcd2(7'(clk_dly_ff[TIME_DELAY-1].mi));
      ss_bcd    = bcd2(7'(clk_dly_ff[TIME_DELAY-1].ss));
      yy_bcd    = bcd2(date.year_ofs);
      mo_bcd    = bcd2(7'(date.month));
      md_bcd    = bcd2(7'(date.mday));
      time_word = {hh_bcd[5:0], 1'b0, mi_bcd[6:0], 1'b0, ss_bcd[6:0]};
      date_word = {yy_bcd, clk_dly_ff[TIME_DELAY-1].wday, mo_bcd[4:0], 2'b00, md_bcd[5:0]};
      rsp_oor_in = !date.in_range;
      if (date.in_range) begin
         rsp_data_in = {2'b00, date_word, time_word};
      end else begin
         rsp_data_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
         rsp_oor_ff  <= rsp_oor_in;
      end
   end

   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_oor_ff;

   // a stall freezes every stage valid bit
   `UBC_ASSERT_NEXT(a_stall_holds_valids, clock, reset,
      !advance, $stable(valid_ff))

   // an out-of-range result carries all-zero words
   `UBC_ASSERT_NOW(a_oor_zero_words, clock, reset,
      rsp_tvalid && rsp_tuser, rsp_tdata == 48'd0)

   // an in-range result has a weekday of 1 to 7 and a month of 1 to 12
   `UBC_ASSERT_NOW(a_weekday_month_legal, clock, reset,
      rsp_tvalid && !rsp_tuser,
      (rsp_tdata[37:35] != 3'd0) && (rsp_tdata[34:30] != 5'h00)
      && (rsp_tdata[34:30] <= 5'h12))

   // an in-range result has hours below 24 in bcd
   `UBC_ASSERT_NOW(a_hours_legal, clock, reset,
      rsp_tvalid && !rsp_tuser, rsp_tdata[21:16] <= 6'h23)

endmodule

`default_nettype wire

@@ test/unix_to_bcd_calendar_core_test.sv @@
// testbench for the unix seconds to bcd calendar core: predicts and checks every transaction
`timescale 1ns / 1ps

module unix_to_bcd_calendar_core_test;

   localparam int unsigned SECS_PER_DAY   = 86400;
   localparam int unsigned EPOCH_TO_ERA0  = 719468;
   localparam int unsigned DAYS_IN_ERA    = 146097;
   localparam int unsigned FIRST_YEAR     = 2000;
   localparam int unsigned LAST_YEAR      = 2099;
   localparam logic [31:0] Y2000_START    = 32'd946684800;
   localparam logic [31:0] Y2100_START    = 32'd4102444800;
   localparam int unsigned FLUSH_CYCLES   = 24;
   localparam int unsigned CYCLE_LIMIT    = 200000;
   localparam int unsigned GAP_PERCENT    = 35;

   // one expected result: the fields of a response transaction
   typedef struct packed {
      logic [21:0] time_word;
      logic [23:0] date_word;
      logic        out_of_range;
   } calendar_words_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // [31:0] unix_seconds
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // [21:0] time_word, [45:22] date_word, [47:46] zero
   logic        rsp_tuser;        // [0] out_of_range

   calendar_words_type pending_words[$];

   bit          sender_gaps_on = 1'b0;
   bit          receiver_gaps_on = 1'b0;
   int unsigned rsp_hold_cycles = 0;
   int unsigned error_count = 0;
   int unsigned stamps_sent = 0;
   int unsigned results_checked = 0;
   int unsigned out_of_range_seen = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned cycle_count = 0;

   unix_to_bcd_calendar_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #2 clock = ~clock;

   // two decimal digits packed as bcd
   function automatic int unsigned to_bcd(input int unsigned value);
      return ((value / 10) << 4) | (value % 10);
   endfunction

   // civil date and time of day of a unix timestamp, packed as the core reports them
   function automatic calendar_words_type calendar_of(input logic [31:0] stamp);
      int unsigned day_no, sec_of_day, hh, mi, ss;
      int unsigned shifted, era, day_in_era, year_in_era, day_in_year, month_idx;
      int unsigned month, mday, year, weekday, tw, dw;
      calendar_words_type words;
      day_no     = stamp / SECS_PER_DAY;
      sec_of_day = stamp % SECS_PER_DAY;
      hh         = sec_of_day / 3600;
      mi         = (sec_of_day % 3600) / 60;
      ss         = sec_of_day % 60;
      // march-based years inside 400-year eras
      shifted     = day_no + EPOCH_TO_ERA0;
      era         = shifted / DAYS_IN_ERA;
      day_in_era  = shifted - era * DAYS_IN_ERA;
      year_in_era = (day_in_era - day_in_era / 1460 + day_in_era / 36524
                     - day_in_era / 146096) / 365;
      day_in_year = day_in_era - (365 * year_in_era + year_in_era / 4 - year_in_era / 100);
      month_idx   = (5 * day_in_year + 2) / 153;
      mday        = day_in_year - (153 * month_idx + 2) / 5 + 1;
      month       = (month_idx < 10) ? month_idx + 3 : month_idx - 9;
      year        = year_in_era + era * 400 + ((month <= 2) ? 1 : 0);
      words = '0;
      if (year < FIRST_YEAR || year > LAST_YEAR) begin
         words.out_of_range = 1'b1;
         return words;
      end
      // 1970-01-01 was a thursday
      weekday = ((day_no + 3) % 7) + 1;
      tw = (to_bcd(hh) << 16) | (to_bcd(mi) << 8) | to_bcd(ss);
      dw = (to_bcd(year - FIRST_YEAR) << 16) | (weekday << 13) | (to_bcd(month) << 8)
         | to_bcd(mday);
      words.time_word = tw[21:0];
      words.date_word = dw[23:0];
      return words;
   endfunction

   // random timestamp, weighted towards the supported century and its edges
   function automatic logic [31:0] pick_timestamp();
      int unsigned pick, day_no;
      logic [31:0] stamp;
      pick = $urandom_range(99);
      if (pick < 55) begin
         stamp = $urandom_range(Y2100_START - 1, Y2000_START);
      end else if (pick < 75) begin
         // midnight or the last second of a day
         day_no = $urandom_range((Y2100_START - 1) / SECS_PER_DAY, Y2000_START / SECS_PER_DAY);
         stamp = day_no * SECS_PER_DAY + ($urandom_range(1) ? SECS_PER_DAY - 1 : 0);
      end else if (pick < 85) begin
         // close to either end of the century
         if ($urandom_range(1))
            stamp = Y2000_START + $urandom_range(200) - 100;
         else
            stamp = Y2100_START + $urandom_range(200) - 100;
      end else begin
         stamp = $urandom();
      end
      return stamp;
   endfunction

   // offer one timestamp and wait for the request transaction
   task automatic send_timestamp(input logic [31:0] stamp);
      // each idle cycle is drawn on its own, so about GAP_PERCENT of cycles idle
      if (sender_gaps_on) begin
         while ($urandom_range(99) < GAP_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= stamp;
      do @(posedge clock); while (!req_tready);
      pending_words.push_back(calendar_of(stamp));
      stamps_sent++;
   endtask

   // stop offering and wait until every expected result has arrived
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // field ends, century edges, leap days and weekday wrap
   task automatic test_directed_dates();
      logic [31:0] stamps[$];
      stamps = '{32'd0, 32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555,
                 32'd946684799, 32'd946684800, 32'd946771200, 32'd946857600,
                 32'd949276800, 32'd951782400, 32'd951868799, 32'd951868800,
                 32'd978307199, 32'd978307200, 32'd1078012800, 32'd1709251199,
                 32'd1709251200, 32'd2147483647, 32'd2147483648, 32'd4102444799,
                 32'd4102444800, 32'd4107542400};
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      foreach (stamps[i]) send_timestamp(stamps[i]);
      drain_results();
   endtask

   // random timestamps with gaps on both sides
   task automatic test_random_timestamps(input int unsigned count);
      sender_gaps_on   = 1'b1;
      receiver_gaps_on = 1'b1;
      repeat (count) send_timestamp(pick_timestamp());
   endtask

   // full rate on both sides, one transaction per cycle
   task automatic test_full_rate(input int unsigned count);
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      repeat (count) send_timestamp(pick_timestamp());
   endtask

   // receiver holds off long enough for the pipeline to fill and block the input
   task automatic test_result_backpressure(input int unsigned count);
      sender_gaps_on   = 1'b0;
      receiver_gaps_on = 1'b0;
      rsp_hold_cycles  = 150;
      repeat (count) send_timestamp(pick_timestamp());
      drain_results();
   endtask

   // result checking and receiver ready pattern
   always @(posedge clock) begin
      calendar_words_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (pending_words.size() == 0) begin
               $display("%0t: unexpected result tdata %h tuser %b", $time, rsp_tdata, rsp_tuser);
               error_count++;
            end else begin
               want = pending_words.pop_front();
               results_checked++;
               if (rsp_tuser) out_of_range_seen++;
               if (rsp_tdata[21:0] !== want.time_word) begin
                  $display("%0t: time_word expected %h got %h", $time, want.time_word,
                           rsp_tdata[21:0]);
                  error_count++;
               end
               if (rsp_tdata[45:22] !== want.date_word) begin
                  $display("%0t: date_word expected %h got %h", $time, want.date_word,
                           rsp_tdata[45:22]);
                  error_count++;
               end
               if (rsp_tuser !== want.out_of_range) begin
                  $display("%0t: out_of_range expected %b got %b", $time, want.out_of_range,
                           rsp_tuser);
                  error_count++;
               end
               if (rsp_tdata[47:46] !== 2'b00) begin
                  $display("%0t: tdata padding expected 0 got %b", $time, rsp_tdata[47:46]);
                  error_count++;
               end
            end
         end
         if (rsp_hold_cycles != 0) begin
            rsp_tready <= 1'b0;
            rsp_hold_cycles--;
         end else if (receiver_gaps_on) begin
            rsp_tready <= ($urandom_range(99) >= GAP_PERCENT);
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // run watchdog and input stall count
   always @(posedge clock) begin
      cycle_count++;
      if (!reset && req_tvalid && !req_tready) input_stall_cycles++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_words.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_dates();
      test_random_timestamps(200);
      test_full_rate(150);
      test_result_backpressure(60);
      test_random_timestamps(220);

      drain_results();
      repeat (FLUSH_CYCLES) @(posedge clock);

      $display("checked %0d of %0d timestamps, %0d outside the supported century",
               results_checked, stamps_sent, out_of_range_seen);
      $display("request side blocked for %0d cycles by result back-pressure",
               input_stall_cycles);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
